// ===== src/rsa_key_setup_and_modexp_assert.svh =====
// Assertion macros for the RSA engine.
// Used by the top level only; needs clk and rst in scope.
`ifndef RSA_KEY_SETUP_AND_MODEXP_ASSERT_SVH
`define RSA_KEY_SETUP_AND_MODEXP_ASSERT_SVH
// Implication checked at every rising clock edge outside reset.
`define RSA_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
// Implication checked in the cycle after the antecedent.
`define RSA_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`endif

// ===== src/rsa_pkg.sv =====
// Shared types and constants of the RSA engine.
// No dependencies.
package rsa_pkg;
  localparam int PRIME_BITS = 16;
  localparam int WORD_BITS = 32;
  localparam int DIV_BITS = 64;

  typedef enum logic [1:0] {
    ACT_ENC    = 2'd0,
    ACT_DEC    = 2'd1,
    ACT_VERIFY = 2'd2,
    ACT_DERIVE = 2'd3
  } action_t;

  typedef enum logic [0:0] {
    REG_P = 1'b0,
    REG_Q = 1'b1
  } reg_idx_t;

  // Request and reply of the shared divider.
  typedef struct packed {
    logic                start;
    logic [DIV_BITS-1:0] dividend;
    logic [DIV_BITS-1:0] divisor;
  } div_req_t;

  typedef struct packed {
    logic                done;
    logic [DIV_BITS-1:0] quotient;
    logic [DIV_BITS-1:0] remainder;
  } div_rsp_t;
endpackage

// ===== src/rsa_div.sv =====
// Restoring binary divider, one quotient bit per cycle.
// Depends on rsa_pkg. Divisor zero is never requested.
module rsa_div import rsa_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);
  logic [DIV_BITS-1:0] quo;
  logic [DIV_BITS-1:0] rem;
  logic [DIV_BITS-1:0] dvs;
  logic [6:0]          cnt;
  logic                busy;
  logic [DIV_BITS:0]   trial;
  logic                done;

  assign trial = {rem, quo[DIV_BITS-1]} - {1'b0, dvs};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        quo  <= req.dividend;
        rem  <= '0;
        dvs  <= req.divisor;
        cnt  <= 7'(DIV_BITS);
      end else if (busy) begin
        // Shift the next dividend bit into the partial remainder.
        if (!trial[DIV_BITS]) begin
          rem <= trial[DIV_BITS-1:0];
          quo <= {quo[DIV_BITS-2:0], 1'b1};
        end else begin
          rem <= {rem[DIV_BITS-2:0], quo[DIV_BITS-1]};
          quo <= {quo[DIV_BITS-2:0], 1'b0};
        end
        cnt <= cnt - 7'd1;
        if (cnt == 7'd1) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done      = done;
  assign rsp.quotient  = quo;
  assign rsp.remainder = rem;
endmodule

// ===== src/rsa_key_setup_and_modexp.sv =====
// Operation: a power takes two divider passes per set exponent bit and one
// per clear bit; derive runs gcd and inverse loops.
// Throughput: one item at a time; the shared 64-bit divider sets the time.
// The result sits in an output register and the next item is taken only after it is accepted.
// Reset (rst, synchronous) restores p=61, q=53, n=3233, e=17, d=2753.
// Depends on rsa_pkg, rsa_div and rsa_key_setup_and_modexp_assert.svh.
`include "rsa_key_setup_and_modexp_assert.svh"
module rsa_key_setup_and_modexp import rsa_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  action,
  input  logic [31:0] value,
  input  logic [31:0] signature,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [31:0] result,
  output logic        valid_res,
  output logic [31:0] exponent
);
  typedef enum logic [15:0] {
    S_IDLE   = 16'h0001,
    S_PSTART = 16'h0002,
    S_PBASE  = 16'h0004,
    S_PLOOP  = 16'h0008,
    S_PMUL   = 16'h0010,
    S_PSQ    = 16'h0020,
    S_GSTART = 16'h0040,
    S_GDIV   = 16'h0080,
    S_GNEXT  = 16'h0100,
    S_ISTART = 16'h0200,
    S_IDIV   = 16'h0400,
    S_IMUL   = 16'h0800,
    S_IEND   = 16'h1000,
    S_DMUL   = 16'h2000,
    S_OUT    = 16'h4000,
    S_PHI    = 16'h8000
  } state_t;

  state_t state;
  logic [PRIME_BITS-1:0] prime_p, prime_q;
  logic [31:0] modulus_n, public_exp, private_exp;
  logic [1:0]  act;
  logic [31:0] val, sig;
  logic [31:0] acc, base;
  logic [31:0] ex;
  logic [63:0] phi;
  logic [63:0] ga, gb;
  logic signed [63:0] ix, iy;
  logic [63:0] cand_e;
  logic        wait_div;
  div_req_t    dreq;
  div_rsp_t    drsp;
  logic [31:0] pm1, qm1;
  logic signed [65:0] iprod;
  logic        div_go;
  logic [31:0] mul_a;
  logic [63:0] mul_prod;

  rsa_div u_div (.clk(clk), .rst(rst), .req(dreq), .rsp(drsp));

  assign pready   = 1'b1;
  assign in_stall = (state != S_IDLE) || out_valid;
  assign pm1 = (prime_p != '0) ? 32'(prime_p) - 32'd1 : 32'd0;
  assign qm1 = (prime_q != '0) ? 32'(prime_q) - 32'd1 : 32'd0;
  // The quotient stays below 2^32 and |y| below phi, so a 33 by 33 product is enough.
  assign iprod = $signed({1'b0, drsp.quotient[31:0]}) * $signed(iy[32:0]);
  // One 32 by 32 multiplier serves both the multiply and the square step.
  assign mul_a    = (state == S_PLOOP && ex[0]) ? acc : base;
  assign mul_prod = 64'(mul_a) * 64'(base);

  always_comb begin
    case (paddr[2])
      REG_P:   prdata = 32'(prime_p);
      REG_Q:   prdata = 32'(prime_q);
      default: prdata = '0;
    endcase
  end

  always_comb begin
    case (state)
      S_PSTART: div_go = (modulus_n != 32'd0);
      S_PLOOP:  div_go = (ex != 32'd0);
      S_PMUL:   div_go = drsp.done;
      S_GDIV:   div_go = (gb != 64'd0) && !wait_div;
      S_IDIV:   div_go = (ga > 64'd1) && (gb != 64'd0);
      default:  div_go = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      prime_p     <= PRIME_BITS'(61);
      prime_q     <= PRIME_BITS'(53);
      modulus_n   <= 32'd3233;
      public_exp  <= 32'd17;
      private_exp <= 32'd2753;
      out_valid   <= 1'b0;
      dreq.start  <= 1'b0;
      wait_div    <= 1'b0;
    end else begin
      dreq.start <= div_go;
      if (out_valid && !out_stall) out_valid <= 1'b0;
      if (psel && penable && pwrite && paddr[1:0] == 2'b00) begin
        if (paddr[2] == REG_P) prime_p <= pwdata[PRIME_BITS-1:0];
        else                   prime_q <= pwdata[PRIME_BITS-1:0];
      end
      case (state)
        S_IDLE: begin
          if (in_valid && !in_stall) begin
            act   <= action;
            val   <= value;
            sig   <= signature;
            state <= (action == ACT_DERIVE) ? S_PHI : S_PSTART;
          end
        end
        S_PSTART: begin
          acc <= (modulus_n == 32'd0) ? 32'd0 : 32'd1;
          ex  <= (act == ACT_DEC) ? private_exp : public_exp;
          if (modulus_n == 32'd0) begin
            state <= S_OUT;
          end else begin
            dreq.dividend <= 64'((act == ACT_VERIFY) ? sig : val);
            dreq.divisor  <= 64'(modulus_n);
            state         <= S_PBASE;
          end
        end
        S_PBASE: if (drsp.done) begin
          base  <= drsp.remainder[31:0];
          state <= S_PLOOP;
        end
        S_PLOOP: begin
          if (ex == 32'd0) state <= S_OUT;
          else if (ex[0]) begin
            dreq.dividend <= mul_prod;
            dreq.divisor  <= 64'(modulus_n);
            state         <= S_PMUL;
          end else begin
            dreq.dividend <= mul_prod;
            dreq.divisor  <= 64'(modulus_n);
            state         <= S_PSQ;
          end
        end
        S_PMUL: if (drsp.done) begin
          acc           <= drsp.remainder[31:0];
          dreq.dividend <= mul_prod;
          dreq.divisor  <= 64'(modulus_n);
          state         <= S_PSQ;
        end
        S_PSQ: if (drsp.done) begin
          base  <= drsp.remainder[31:0];
          ex    <= ex >> 1;
          state <= S_PLOOP;
        end
        S_PHI: begin
          modulus_n <= 32'(prime_p) * 32'(prime_q);
          phi       <= 64'(pm1 * qm1);
          cand_e    <= 64'd17;
          state     <= S_GSTART;
        end
        S_GSTART: begin
          if (phi == 64'd0) begin
            public_exp  <= 32'd17;
            private_exp <= 32'd0;
            state       <= S_DMUL;
          end else begin
            ga    <= cand_e;
            gb    <= phi;
            state <= S_GDIV;
          end
        end
        S_GDIV: begin
          if (gb == 64'd0) state <= S_GNEXT;
          else if (!wait_div) begin
            dreq.dividend <= ga;
            dreq.divisor  <= gb;
            wait_div      <= 1'b1;
          end else if (drsp.done) begin
            ga       <= gb;
            gb       <= drsp.remainder;
            wait_div <= 1'b0;
          end
        end
        S_GNEXT: begin
          if (ga == 64'd1) begin
            public_exp <= cand_e[31:0];
            state      <= S_ISTART;
          end else if (cand_e < 64'hFFFF_FFFD) begin
            cand_e <= cand_e + 64'd2;
            state  <= S_GSTART;
          end else begin
            cand_e     <= 64'hFFFF_FFFF;
            public_exp <= 32'hFFFF_FFFF;
            state      <= S_ISTART;
          end
        end
        S_ISTART: begin
          ga <= cand_e;
          gb <= phi;
          ix <= 64'sd1;
          iy <= 64'sd0;
          if (phi <= 64'd1) begin
            private_exp <= 32'd0;
            state       <= S_DMUL;
          end else state <= S_IDIV;
        end
        S_IDIV: begin
          if (ga <= 64'd1 || gb == 64'd0) state <= S_IEND;
          else begin
            dreq.dividend <= ga;
            dreq.divisor  <= gb;
            state         <= S_IMUL;
          end
        end
        S_IMUL: if (drsp.done) begin
          ga    <= gb;
          gb    <= drsp.remainder;
          iy    <= ix - $signed(iprod[63:0]);
          ix    <= iy;
          state <= S_IDIV;
        end
        S_IEND: begin
          private_exp <= (ix < 0) ? 32'(ix + $signed(phi)) : ix[31:0];
          state       <= S_DMUL;
        end
        S_DMUL: state <= S_OUT;
        S_OUT: begin
          if (!out_valid) begin
            out_valid <= 1'b1;
            valid_res <= (act == ACT_VERIFY) && (acc == val);
            if (act == ACT_DERIVE) begin
              result   <= modulus_n;
              exponent <= public_exp;
            end else begin
              result   <= acc;
              exponent <= 32'd0;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `RSA_ASSERT_IMP(a_busy_stalls, state != S_IDLE, in_stall)
  `RSA_ASSERT_NEXT(a_accept_leaves_idle, in_valid && !in_stall, state != S_IDLE)
  `RSA_ASSERT_NEXT(a_out_holds, out_valid && out_stall, out_valid && $stable(result))
endmodule
